// File: rtl/rth_pkg.sv
package rth_pkg;

   localparam int CHAN_BITS = 8;
   localparam int HUE_BITS = 15;
   localparam int SAT_BITS = 16;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_BITS = RECIP_SHIFT + 1;
   localparam int HUE_Q_BITS = 12;
   localparam int HUE_NUM_BITS = 20;
   localparam int SAT_NUM_BITS = 24;
   localparam int REM_BITS = CHAN_BITS + 2;
   localparam int HUE_SIXTH = 3840;
   localparam int HUE_FULL = 23040;

   typedef logic [CHAN_BITS-1:0] chan_type;
   typedef logic [HUE_BITS-1:0] hue_type;
   typedef logic [SAT_BITS-1:0] sat_type;
   typedef logic [RECIP_BITS-1:0] recip_type;

   typedef enum logic [1:0] {
      SEL_RED,
      SEL_GREEN,
      SEL_BLUE
   } sel_type;

endpackage

// File: rtl/rth_if.sv
interface rth_req_if;
   logic valid;
   logic ready;
   rth_pkg::chan_type red;
   rth_pkg::chan_type green;
   rth_pkg::chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_rsp_if;
   logic valid;
   logic ready;
   rth_pkg::hue_type hue;
   rth_pkg::sat_type saturation;
   rth_pkg::chan_type brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

// File: rtl/rgb_to_hsv_pixel_unit.sv
// RGB to HSV pixel converter.
// The req_bus channel carries one pixel per item as red, green and blue bytes.
// The rsp_bus channel returns one item per pixel with hue in 1/64 degree,
// saturation scaled so 65535 means 1.0, and brightness as the largest channel.
// Items move with valid and ready and are taken at an edge where both are high.
// The block is a five-stage pipeline: min/max, reciprocal lookup, reciprocal
// multiply, remainder check, and hue assembly into the output register.
// One pixel can be accepted in every cycle unless rsp_bus.ready is low with a
// result waiting, so the sustained rate is one item per cycle.
// Both divisions use a 256-entry reciprocal table followed by a single
// correction step, which sets the depth of the pipeline.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and req_bus.ready goes low; nothing is lost or repeated.
// Synchronous reset clears all stage valid bits, so the pipeline comes up
// empty; results in flight at reset are dropped.
module rgb_to_hsv_pixel_unit (
   input logic clock,
   input logic reset,
   rth_req_if.sink req_bus,
   rth_rsp_if.source rsp_bus
);

   rth_pkg::recip_type recip_tbl [2**rth_pkg::CHAN_BITS];

   for (genvar i = 0; i < 2**rth_pkg::CHAN_BITS; i++) begin : g_recip
      localparam longint RecipVal = (i == 0) ? 0 : (64'd1 << rth_pkg::RECIP_SHIFT) / i;
      assign recip_tbl[i] = rth_pkg::RECIP_BITS'(RecipVal);
   end

   logic advance;

   // Stage 1: max, min, delta and the signed difference.
   logic v1_ff;
   rth_pkg::chan_type mx1_ff, mx1_in, delta1_ff, delta1_in, absd1_ff, absd1_in;
   logic neg1_ff, neg1_in, grey1_ff, grey1_in;
   rth_pkg::sel_type sel1_ff, sel1_in;
   rth_pkg::chan_type mn1;
   logic signed [rth_pkg::CHAN_BITS:0] diff1;

   // Stage 2: numerators and reciprocals.
   logic v2_ff;
   rth_pkg::chan_type mx2_ff, delta2_ff;
   logic neg2_ff, grey2_ff;
   rth_pkg::sel_type sel2_ff;
   logic [rth_pkg::HUE_NUM_BITS-1:0] nh2_ff, nh2_in;
   logic [rth_pkg::SAT_NUM_BITS-1:0] ns2_ff, ns2_in;
   rth_pkg::recip_type rd2_ff, rd2_in, rm2_ff, rm2_in;

   // Stage 3: estimated quotients.
   logic v3_ff;
   rth_pkg::chan_type mx3_ff, delta3_ff;
   logic neg3_ff, grey3_ff;
   rth_pkg::sel_type sel3_ff;
   logic [rth_pkg::HUE_NUM_BITS-1:0] nh3_ff;
   logic [rth_pkg::SAT_NUM_BITS-1:0] ns3_ff;
   logic [rth_pkg::HUE_Q_BITS-1:0] qh3_ff, qh3_in;
   rth_pkg::sat_type qs3_ff, qs3_in;
   logic [rth_pkg::HUE_NUM_BITS+rth_pkg::RECIP_BITS-1:0] ph3;
   logic [rth_pkg::SAT_NUM_BITS+rth_pkg::RECIP_BITS-1:0] ps3;

   // Stage 4: remainders.
   logic v4_ff;
   rth_pkg::chan_type mx4_ff, delta4_ff;
   logic neg4_ff, grey4_ff;
   rth_pkg::sel_type sel4_ff;
   logic [rth_pkg::HUE_Q_BITS-1:0] qh4_ff;
   rth_pkg::sat_type qs4_ff;
   logic [rth_pkg::REM_BITS-1:0] rh4_ff, rh4_in, rs4_ff, rs4_in;
   logic [rth_pkg::HUE_NUM_BITS-1:0] rh4_full;
   logic [rth_pkg::SAT_NUM_BITS-1:0] rs4_full;

   // Stage 5: output register.
   logic v5_ff;
   rth_pkg::hue_type hue5_ff, hue5_in;
   rth_pkg::sat_type sat5_ff, sat5_in;
   rth_pkg::chan_type bright5_ff;
   logic [rth_pkg::HUE_Q_BITS-1:0] qh5;
   rth_pkg::sat_type qs5;
   logic signed [rth_pkg::HUE_BITS:0] base5, sq5, hs5;

   assign advance = !v5_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   assign rsp_bus.valid = v5_ff;
   assign rsp_bus.hue = hue5_ff;
   assign rsp_bus.saturation = sat5_ff;
   assign rsp_bus.brightness = bright5_ff;

   always_comb begin
      mx1_in = req_bus.red;
      mn1 = req_bus.red;
      if (req_bus.green > mx1_in) mx1_in = req_bus.green;
      if (req_bus.blue > mx1_in) mx1_in = req_bus.blue;
      if (req_bus.green < mn1) mn1 = req_bus.green;
      if (req_bus.blue < mn1) mn1 = req_bus.blue;
      delta1_in = mx1_in - mn1;
      grey1_in = (delta1_in == '0);
      if (req_bus.red == mx1_in) begin
         sel1_in = rth_pkg::SEL_RED;
         diff1 = $signed({1'b0, req_bus.green}) - $signed({1'b0, req_bus.blue});
      end else if (req_bus.green == mx1_in) begin
         sel1_in = rth_pkg::SEL_GREEN;
         diff1 = $signed({1'b0, req_bus.blue}) - $signed({1'b0, req_bus.red});
      end else begin
         sel1_in = rth_pkg::SEL_BLUE;
         diff1 = $signed({1'b0, req_bus.red}) - $signed({1'b0, req_bus.green});
      end
      neg1_in = diff1[rth_pkg::CHAN_BITS];
      if (neg1_in) begin
         absd1_in = rth_pkg::CHAN_BITS'(-diff1);
      end else begin
         absd1_in = rth_pkg::CHAN_BITS'(diff1);
      end
   end

   always_comb begin
      nh2_in = rth_pkg::HUE_NUM_BITS'(absd1_ff) *
               rth_pkg::HUE_NUM_BITS'(rth_pkg::HUE_SIXTH);
      ns2_in = {delta1_ff, rth_pkg::SAT_BITS'(0)} - rth_pkg::SAT_NUM_BITS'(delta1_ff);
      rd2_in = recip_tbl[delta1_ff];
      rm2_in = recip_tbl[mx1_ff];
   end

   always_comb begin
      ph3 = $bits(ph3)'(nh2_ff) * $bits(ph3)'(rd2_ff);
      ps3 = $bits(ps3)'(ns2_ff) * $bits(ps3)'(rm2_ff);
      qh3_in = ph3[rth_pkg::RECIP_SHIFT +: rth_pkg::HUE_Q_BITS];
      qs3_in = ps3[rth_pkg::RECIP_SHIFT +: rth_pkg::SAT_BITS];
   end

   always_comb begin
      rh4_full = nh3_ff - rth_pkg::HUE_NUM_BITS'(qh3_ff) * rth_pkg::HUE_NUM_BITS'(delta3_ff);
      rs4_full = ns3_ff - rth_pkg::SAT_NUM_BITS'(qs3_ff) * rth_pkg::SAT_NUM_BITS'(mx3_ff);
      rh4_in = rh4_full[rth_pkg::REM_BITS-1:0];
      rs4_in = rs4_full[rth_pkg::REM_BITS-1:0];
   end

   always_comb begin
      qh5 = qh4_ff + rth_pkg::HUE_Q_BITS'(rh4_ff >= rth_pkg::REM_BITS'(delta4_ff));
      qs5 = qs4_ff + rth_pkg::SAT_BITS'(rs4_ff >= rth_pkg::REM_BITS'(mx4_ff));
      case (sel4_ff)
         rth_pkg::SEL_RED: base5 = '0;
         rth_pkg::SEL_GREEN: base5 = (rth_pkg::HUE_BITS+1)'(2 * rth_pkg::HUE_SIXTH);
         rth_pkg::SEL_BLUE: base5 = (rth_pkg::HUE_BITS+1)'(4 * rth_pkg::HUE_SIXTH);
         default: base5 = '0;
      endcase
      sq5 = $signed((rth_pkg::HUE_BITS+1)'(qh5));
      if (neg4_ff) begin
         hs5 = base5 - sq5;
      end else begin
         hs5 = base5 + sq5;
      end
      if (hs5 < 0) begin
         hs5 = hs5 + (rth_pkg::HUE_BITS+1)'(rth_pkg::HUE_FULL);
      end
      if (grey4_ff) begin
         hue5_in = '0;
         sat5_in = '0;
      end else begin
         hue5_in = hs5[rth_pkg::HUE_BITS-1:0];
         sat5_in = qs5;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mx1_ff <= mx1_in;
         delta1_ff <= delta1_in;
         absd1_ff <= absd1_in;
         neg1_ff <= neg1_in;
         grey1_ff <= grey1_in;
         sel1_ff <= sel1_in;

         mx2_ff <= mx1_ff;
         delta2_ff <= delta1_ff;
         neg2_ff <= neg1_ff;
         grey2_ff <= grey1_ff;
         sel2_ff <= sel1_ff;
         nh2_ff <= nh2_in;
         ns2_ff <= ns2_in;
         rd2_ff <= rd2_in;
         rm2_ff <= rm2_in;

         mx3_ff <= mx2_ff;
         delta3_ff <= delta2_ff;
         neg3_ff <= neg2_ff;
         grey3_ff <= grey2_ff;
         sel3_ff <= sel2_ff;
         nh3_ff <= nh2_ff;
         ns3_ff <= ns2_ff;
         qh3_ff <= qh3_in;
         qs3_ff <= qs3_in;

         mx4_ff <= mx3_ff;
         delta4_ff <= delta3_ff;
         neg4_ff <= neg3_ff;
         grey4_ff <= grey3_ff;
         sel4_ff <= sel3_ff;
         qh4_ff <= qh3_ff;
         qs4_ff <= qs3_ff;
         rh4_ff <= rh4_in;
         rs4_ff <= rs4_in;

         hue5_ff <= hue5_in;
         sat5_ff <= sat5_in;
         bright5_ff <= mx4_ff;
      end
   end

endmodule
